@@ hw/rtl/cdb_pkg.sv @@
package cdb_pkg;

   localparam int DATA_W    = 16;
   localparam int CAP_W     = 6;
   localparam int OFFSET_W  = 5;
   localparam int OP_W      = 3;
   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 24;

   localparam logic [CAP_W-1:0] CAP_RESET = 6'd32;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH_TAIL = 3'd0,
      OP_PUSH_HEAD = 3'd1,
      OP_POP_HEAD  = 3'd2,
      OP_POP_TAIL  = 3'd3,
      OP_PEEK_HEAD = 3'd4,
      OP_PEEK_TAIL = 3'd5,
      OP_READ_AT   = 3'd6,
      OP_CLEAR     = 3'd7
   } req_op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_OVERWRITE = 2'd1,
      ST_EMPTY     = 2'd2,
      ST_RANGE     = 2'd3
   } status_type;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } mem_cmd_type;

   typedef struct packed {
      status_type       status;
      logic [CAP_W-1:0] fill_count;
      logic             use_data;
   } result_meta_type;

endpackage

@@ hw/rtl/cdb_mem.sv @@
module cdb_mem #(
   parameter int  DEPTH  = 32,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic                       clock,
   input  cdb_pkg::mem_cmd_type       cmd,
   input  logic [ADDR_W-1:0]          addr,
   input  logic [cdb_pkg::DATA_W-1:0] wr_data,
   output logic [cdb_pkg::DATA_W-1:0] rd_data
);
   import cdb_pkg::*;

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/cdb_ctrl.sv @@
module cdb_ctrl #(
   parameter int  DEPTH  = 32,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_wen,
   input  logic [cdb_pkg::CAP_W-1:0]    csr_wdata,
   input  logic                         accept,
   input  cdb_pkg::req_op_type          op,
   input  logic [cdb_pkg::DATA_W-1:0]   value,
   input  logic [cdb_pkg::OFFSET_W-1:0] offset,
   output cdb_pkg::mem_cmd_type         mem_cmd,
   output logic [ADDR_W-1:0]            mem_addr,
   output logic [cdb_pkg::DATA_W-1:0]   mem_wr_data,
   output cdb_pkg::result_meta_type     meta
);
   import cdb_pkg::*;

   logic [CAP_W-1:0] cap_ff, cap_in;
   logic [CAP_W-1:0] head_ff, head_in;
   logic [CAP_W-1:0] tail_ff, tail_in;
   logic [CAP_W-1:0] count_ff, count_in;

   logic [CAP_W-1:0] cap_eff;
   logic [CAP_W-1:0] head_inc, head_dec, tail_inc, tail_dec;
   logic [CAP_W:0]   at_sum;
   logic [CAP_W-1:0] at_ptr;
   logic [CAP_W-1:0] ptr_sel;
   logic             full, empty;

   function automatic logic [CAP_W-1:0] ptr_inc(logic [CAP_W-1:0] p, logic [CAP_W-1:0] cap);
      logic [CAP_W:0] p1;
      p1 = {1'b0, p} + (CAP_W+1)'(1);
      return (p1 >= {1'b0, cap}) ? '0 : p1[CAP_W-1:0];
   endfunction

   function automatic logic [CAP_W-1:0] ptr_dec(logic [CAP_W-1:0] p, logic [CAP_W-1:0] cap);
      return (p == '0 || p >= cap) ? cap - CAP_W'(1) : p - CAP_W'(1);
   endfunction

   always_comb begin
      if (cap_ff == '0) begin
         cap_eff = CAP_W'(1);
      end else if (int'(cap_ff) > DEPTH) begin
         cap_eff = CAP_W'(DEPTH);
      end else begin
         cap_eff = cap_ff;
      end
   end

   assign head_inc = ptr_inc(head_ff, cap_eff);
   assign head_dec = ptr_dec(head_ff, cap_eff);
   assign tail_inc = ptr_inc(tail_ff, cap_eff);
   assign tail_dec = ptr_dec(tail_ff, cap_eff);
   assign full     = (count_ff >= cap_eff);
   assign empty    = (count_ff == '0);

   always_comb begin
      at_sum = {1'b0, head_ff} + (CAP_W+1)'(offset);
      if (at_sum >= {1'b0, cap_eff}) begin
         at_sum = at_sum - {1'b0, cap_eff};
      end
      at_ptr = at_sum[CAP_W-1:0];
   end

   always_comb begin
      cap_in        = cap_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      mem_cmd       = '0;
      ptr_sel       = head_ff;
      meta.status   = ST_OK;
      meta.use_data = 1'b0;

      if (csr_wen) begin
         cap_in   = csr_wdata;
         head_in  = '0;
         tail_in  = '0;
         count_in = '0;
      end else if (accept) begin
         unique case (op)
            OP_PUSH_TAIL: begin
               mem_cmd.wr_en = 1'b1;
               ptr_sel       = tail_ff;
               tail_in       = tail_inc;
               if (full) begin
                  head_in     = head_inc;
                  meta.status = ST_OVERWRITE;
               end else begin
                  count_in = count_ff + CAP_W'(1);
               end
            end
            OP_PUSH_HEAD: begin
               mem_cmd.wr_en = 1'b1;
               ptr_sel       = head_dec;
               head_in       = head_dec;
               if (full) begin
                  tail_in     = tail_dec;
                  meta.status = ST_OVERWRITE;
               end else begin
                  count_in = count_ff + CAP_W'(1);
               end
            end
            OP_POP_HEAD, OP_PEEK_HEAD: begin
               if (empty) begin
                  meta.status = ST_EMPTY;
               end else begin
                  mem_cmd.rd_en = 1'b1;
                  meta.use_data = 1'b1;
                  ptr_sel       = head_ff;
                  if (op == OP_POP_HEAD) begin
                     head_in  = head_inc;
                     count_in = count_ff - CAP_W'(1);
                  end
               end
            end
            OP_POP_TAIL, OP_PEEK_TAIL: begin
               if (empty) begin
                  meta.status = ST_EMPTY;
               end else begin
                  mem_cmd.rd_en = 1'b1;
                  meta.use_data = 1'b1;
                  ptr_sel       = tail_dec;
                  if (op == OP_POP_TAIL) begin
                     tail_in  = tail_dec;
                     count_in = count_ff - CAP_W'(1);
                  end
               end
            end
            OP_READ_AT: begin
               if (empty) begin
                  meta.status = ST_EMPTY;
               end else if (CAP_W'(offset) >= count_ff) begin
                  meta.status = ST_RANGE;
               end else begin
                  mem_cmd.rd_en = 1'b1;
                  meta.use_data = 1'b1;
                  ptr_sel       = at_ptr;
               end
            end
            OP_CLEAR: begin
               head_in  = '0;
               tail_in  = '0;
               count_in = '0;
            end
         endcase
      end
      meta.fill_count = count_in;
   end

   assign mem_addr    = ADDR_W'(ptr_sel);
   assign mem_wr_data = value;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff   <= CAP_RESET;
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         cap_ff   <= cap_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   logic [CAP_W:0]   inv_sum;
   logic [CAP_W-1:0] inv_tail;

   always_comb begin
      inv_sum = {1'b0, head_ff} + {1'b0, count_ff};
      if (inv_sum >= {1'b0, cap_eff}) begin
         inv_sum = inv_sum - {1'b0, cap_eff};
      end
      inv_tail = inv_sum[CAP_W-1:0];
   end

   a_count_within_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= cap_eff)
      else $error("entry count above capacity");

   a_ptrs_within_cap: assert property (@(posedge clock) disable iff (reset)
      head_ff < cap_eff && tail_ff < cap_eff)
      else $error("pointer outside ring");

   a_tail_tracks_head: assert property (@(posedge clock) disable iff (reset)
      tail_ff == inv_tail)
      else $error("tail out of step with head and count");

endmodule

@@ hw/rtl/circular_deque_buffer.sv @@
// Pipeline: the RAM read and the request's status are registered in stage s1, then the result
// beat is registered for rsp; a stall on rsp_tready can hold it in either register.
// Throughput: one request per cycle unless rsp stalls; at most one RAM access per request.
// Reset (synchronous, active high): head, tail and count go to zero, capacity to 32.
// Slot storage is not cleared at reset; a capacity write also empties the buffer.
module circular_deque_buffer #(
   parameter int DEPTH = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [cdb_pkg::REQ_TDATA_W-1:0]   req_tdata,  // value[15:0], offset[20:16], zero
   input  logic [cdb_pkg::OP_W-1:0]          req_tuser,  // req_type[2:0]
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [cdb_pkg::RSP_TDATA_W-1:0]   rsp_tdata,  // data_out[15:0], status[17:16],
                                                         // fill_count[23:18]
   input  logic                              csr_wen,
   input  logic [cdb_pkg::CAP_W-1:0]         csr_wdata
);
   import cdb_pkg::*;

   localparam int ADDR_W = $clog2(DEPTH);

   logic              accept;
   logic              s1_move;
   mem_cmd_type       mem_cmd;
   logic [ADDR_W-1:0] mem_addr;
   logic [DATA_W-1:0] mem_wr_data;
   logic [DATA_W-1:0] mem_rd_data;
   result_meta_type   meta;

   logic              s1_valid_ff, s1_valid_in;
   result_meta_type   s1_meta_ff, s1_meta_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   assign s1_move    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || s1_move;
   assign accept     = req_tvalid && req_tready;

   cdb_ctrl #(
      .DEPTH(DEPTH)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .accept     (accept),
      .op         (req_op_type'(req_tuser)),
      .value      (req_tdata[DATA_W-1:0]),
      .offset     (req_tdata[DATA_W +: OFFSET_W]),
      .mem_cmd    (mem_cmd),
      .mem_addr   (mem_addr),
      .mem_wr_data(mem_wr_data),
      .meta       (meta)
   );

   cdb_mem #(
      .DEPTH(DEPTH)
   ) u_mem (
      .clock  (clock),
      .cmd    (mem_cmd),
      .addr   (mem_addr),
      .wr_data(mem_wr_data),
      .rd_data(mem_rd_data)
   );

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_meta_in   = s1_meta_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (s1_valid_ff && s1_move) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {s1_meta_ff.fill_count, s1_meta_ff.status,
                         s1_meta_ff.use_data ? mem_rd_data : DATA_W'(0)};
         s1_valid_in  = 1'b0;
      end
      if (accept) begin
         s1_valid_in = 1'b1;
         s1_meta_in  = meta;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      s1_meta_ff  <= s1_meta_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_no_accept_when_blocked: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && rsp_valid_ff && !rsp_tready |-> !req_tready)
      else $error("request taken while both stages are held");

   a_rsp_from_s1: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_valid_ff))
      else $error("result beat without a request in flight");

   a_error_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff[DATA_W +: 2] != 2'(ST_OK) |-> rsp_data_ff[DATA_W-1:0] == '0)
      else $error("data returned with non-ok status");

endmodule
